// ===== rtl/core/three_digit_stopwatch_display_macros.svh =====
// Assertion macros used by the stopwatch checker.
`ifndef THREE_DIGIT_STOPWATCH_DISPLAY_MACROS_SVH
`define THREE_DIGIT_STOPWATCH_DISPLAY_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define TDSD_ASSERT_NOW(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("stopwatch check failed (same cycle)");

// Next-cycle implication, sampled on clock, off during reset.
`define TDSD_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("stopwatch check failed (next cycle)");

`endif

// ===== rtl/core/tdsd_pkg.sv =====
// Package: types, constants and decode functions of the stopwatch display.
`default_nettype none
package tdsd_pkg;

   localparam int NUM_DIGITS_DEF = 3;
   localparam int CSR_AW         = 4;
   localparam int CSR_DW         = 32;

   localparam logic [7:0]  DEBOUNCE_MS_RST     = 8'd50;
   localparam logic [15:0] COUNT_PERIOD_MS_RST = 16'd1000;
   localparam logic [7:0]  MUX_MS_RST          = 8'd30;
   localparam logic [3:0]  BCD_MAX             = 4'd9;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
   localparam logic [1:0] REG_COUNT_PERIOD = 2'd1;
   localparam logic [1:0] REG_MUX          = 2'd2;

   // run_mode codes seen on the result channel
   localparam logic [1:0] RUN_STOPPED  = 2'd0;
   localparam logic [1:0] RUN_RUNNING  = 2'd1;
   localparam logic [1:0] RUN_STOPPING = 2'd2;
   localparam logic [1:0] RUN_ALARM    = 2'd3;

   typedef enum logic [3:0] {
      MODE_STOPPED  = 4'b0001,
      MODE_RUNNING  = 4'b0010,
      MODE_STOPPING = 4'b0100,
      MODE_ALARM    = 4'b1000
   } mode_type;

   typedef struct packed {
      logic start;
      logic clear;
   } press_type;

   function automatic logic [1:0] mode_code(input mode_type m);
      logic [1:0] c;
      case (m)
         MODE_RUNNING:  c = RUN_RUNNING;
         MODE_STOPPING: c = RUN_STOPPING;
         MODE_ALARM:    c = RUN_ALARM;
         default:       c = RUN_STOPPED;
      endcase
      return c;
   endfunction

   // segments a..g on bits 0..6; non-BCD codes dark
   function automatic logic [6:0] seg_decode(input logic [3:0] d);
      logic [6:0] s;
      case (d)
         4'd0:    s = 7'h3F;
         4'd1:    s = 7'h06;
         4'd2:    s = 7'h5B;
         4'd3:    s = 7'h4F;
         4'd4:    s = 7'h66;
         4'd5:    s = 7'h6D;
         4'd6:    s = 7'h7D;
         4'd7:    s = 7'h07;
         4'd8:    s = 7'h7F;
         4'd9:    s = 7'h6F;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tdsd_debounce.sv =====
// Debouncer for one raw button level, counting millisecond ticks.
`default_nettype none
module tdsd_debounce (
   input  logic       clock,
   input  logic       reset,
   input  logic       enable,
   input  logic       tick,
   input  logic       raw,
   input  logic [7:0] debounce_ms,
   output logic       press
);

   logic [7:0] cnt_ff, cnt_in;
   logic       last_ff, last_in;
   logic       level_ff, level_in;
   logic [7:0] step;

   always_comb begin
      cnt_in   = cnt_ff;
      level_in = level_ff;
      last_in  = raw;
      press    = 1'b0;
      step     = cnt_ff;
      if (raw != last_ff) begin
         cnt_in = '0;
      end else begin
         // saturate at the threshold
         if (tick && (cnt_ff < debounce_ms)) begin
            step = cnt_ff + 8'd1;
         end
         cnt_in = step;
         if ((step >= debounce_ms) && (raw != level_ff)) begin
            level_in = raw;
            press    = raw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
         level_ff <= 1'b0;
      end else if (enable) begin
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
         level_ff <= level_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/tdsd_count.sv =====
// Run-mode state machine, period counter and saturating BCD count.
`default_nettype none
module tdsd_count
   import tdsd_pkg::*;
#(
   parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       tick,
   input  press_type                  press,
   input  logic [15:0]                count_period_ms,
   output logic [NUM_DIGITS-1:0][3:0] digits_in,
   output mode_type                   mode_in
);

   logic [NUM_DIGITS-1:0][3:0] digits_ff;
   mode_type                   mode_ff;
   logic [15:0]                period_ff, period_in;
   logic [NUM_DIGITS-1:0][3:0] digits_inc;
   logic                       all_nine;
   logic                       carry;
   logic                       changed;
   logic [16:0]                period_next;

   // ripple increment across the digits
   always_comb begin
      carry    = 1'b1;
      all_nine = 1'b1;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         digits_inc[i] = digits_ff[i];
         if (digits_ff[i] != BCD_MAX) begin
            all_nine = 1'b0;
         end
         if (carry) begin
            if (digits_ff[i] < BCD_MAX) begin
               digits_inc[i] = digits_ff[i] + 4'd1;
               carry         = 1'b0;
            end else begin
               digits_inc[i] = '0;
            end
         end
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      period_in   = period_ff;
      digits_in   = digits_ff;
      changed     = 1'b0;
      period_next = {1'b0, period_ff} + 17'd1;
      case (mode_ff)
         MODE_STOPPED: begin
            if (press.start) begin
               mode_in   = MODE_RUNNING;
               period_in = '0;
               changed   = 1'b1;
            end else if (press.clear) begin
               digits_in = '0;
            end
         end
         MODE_RUNNING: begin
            if (press.start) begin
               mode_in   = MODE_STOPPING;
               period_in = '0;
               changed   = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (!changed && tick && ((mode_ff == MODE_RUNNING) || (mode_ff == MODE_STOPPING))) begin
         if (period_next >= {1'b0, count_period_ms}) begin
            period_in = '0;
            if (all_nine) begin
               mode_in = MODE_ALARM;
            end else begin
               digits_in = digits_inc;
               if (mode_ff == MODE_STOPPING) begin
                  mode_in = MODE_STOPPED;
               end
            end
         end else begin
            period_in = period_next[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_STOPPED;
         period_ff <= '0;
         digits_ff <= '0;
      end else if (enable) begin
         mode_ff   <= mode_in;
         period_ff <= period_in;
         digits_ff <= digits_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/tdsd_scan.sv =====
// Display scan: digit select counter and segment decode of the selected digit.
`default_nettype none
module tdsd_scan
   import tdsd_pkg::*;
#(
   parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       tick,
   input  logic [7:0]                 mux_ms,
   input  logic [NUM_DIGITS-1:0][3:0] digits,
   output logic [6:0]                 segment_in,
   output logic [2:0]                 enable_in
);

   localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_DIGITS - 1);

   logic [7:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [8:0]       cnt_next;

   always_comb begin
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      cnt_next = {1'b0, cnt_ff} + 9'd1;
      if (tick) begin
         if (cnt_next >= {1'b0, mux_ms}) begin
            cnt_in = '0;
            idx_in = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
         end else begin
            cnt_in = cnt_next[7:0];
         end
      end
      segment_in = seg_decode(digits[idx_in]);
      // only three enable lines exist; higher digits show none
      for (int j = 0; j < 3; j++) begin
         enable_in[j] = (j < NUM_DIGITS) && (32'(idx_in) == j);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (enable) begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/three_digit_stopwatch_display.sv =====
// Top level: stopwatch with debounced buttons and multiplexed 7-segment output.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   ms_tick, start_level, clear_level
//   rsp      out        rsp_valid / rsp_stall   segments, enable, digits, run_mode
//   csr      in/out     APB psel/penable        debounce, period, mux registers
//
// One item a clock while req_stall is low: the input item and the current
// state go through one level of counters and compares and land in the result
// register on the same edge, and rsp_valid rises in the cycle after accept.
// The result register is the only buffer, so req_stall rises only while a
// result waits under rsp_stall. Synchronous reset clears all counters, the mode,
// the digits and rsp_valid, and loads the register defaults (50 / 1000 / 30 ms).
`default_nettype none
module three_digit_stopwatch_display
   import tdsd_pkg::*;
#(
   parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // input items
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_ms_tick,
   input  logic              req_start_level,
   input  logic              req_clear_level,
   // result items
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [6:0]        rsp_segment_pattern,
   output logic [2:0]        rsp_digit_enable,
   output logic [3:0]        rsp_units_digit,
   output logic [3:0]        rsp_tens_digit,
   output logic [3:0]        rsp_hundreds_digit,
   output logic [1:0]        rsp_run_mode,
   // configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   // configuration registers
   logic [7:0]  debounce_ms_ff;
   logic [15:0] count_period_ms_ff;
   logic [7:0]  mux_ms_ff;
   logic        csr_write;
   logic [1:0]  csr_index;

   // handshake
   logic accept;
   logic rsp_valid_ff, rsp_valid_in;

   // next state from the units
   press_type                  press;
   logic [NUM_DIGITS-1:0][3:0] digits_in;
   mode_type                   mode_in;
   logic [6:0]                 segment_in;
   logic [2:0]                 enable_in;
   logic [3:0]                 tens_in, hundreds_in;

   // result register
   logic [6:0] segment_ff;
   logic [2:0] enable_ff;
   logic [3:0] units_ff, tens_ff, hundreds_ff;
   logic [1:0] run_mode_ff;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff     <= DEBOUNCE_MS_RST;
         count_period_ms_ff <= COUNT_PERIOD_MS_RST;
         mux_ms_ff          <= MUX_MS_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_DEBOUNCE:     debounce_ms_ff     <= csr_pwdata[7:0];
            REG_COUNT_PERIOD: count_period_ms_ff <= csr_pwdata[15:0];
            REG_MUX:          mux_ms_ff          <= csr_pwdata[7:0];
            default: begin
               // drop writes past the register list
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_DEBOUNCE:     csr_prdata = {24'd0, debounce_ms_ff};
         REG_COUNT_PERIOD: csr_prdata = {16'd0, count_period_ms_ff};
         REG_MUX:          csr_prdata = {24'd0, mux_ms_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- handshake
   // Take an item whenever the result register is empty or being drained.
   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   // -------------------------------------------------------------- units
   tdsd_debounce u_start_db (
      .clock       (clock),
      .reset       (reset),
      .enable      (accept),
      .tick        (req_ms_tick),
      .raw         (req_start_level),
      .debounce_ms (debounce_ms_ff),
      .press       (press.start)
   );

   tdsd_debounce u_clear_db (
      .clock       (clock),
      .reset       (reset),
      .enable      (accept),
      .tick        (req_ms_tick),
      .raw         (req_clear_level),
      .debounce_ms (debounce_ms_ff),
      .press       (press.clear)
   );

   tdsd_count #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_count (
      .clock           (clock),
      .reset           (reset),
      .enable          (accept),
      .tick            (req_ms_tick),
      .press           (press),
      .count_period_ms (count_period_ms_ff),
      .digits_in       (digits_in),
      .mode_in         (mode_in)
   );

   tdsd_scan #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .enable     (accept),
      .tick       (req_ms_tick),
      .mux_ms     (mux_ms_ff),
      .digits     (digits_in),
      .segment_in (segment_in),
      .enable_in  (enable_in)
   );

   // absent digits read as zero
   generate
      if (NUM_DIGITS > 1) begin : g_tens
         assign tens_in = digits_in[1];
      end else begin : g_no_tens
         assign tens_in = '0;
      end
      if (NUM_DIGITS > 2) begin : g_hundreds
         assign hundreds_in = digits_in[2];
      end else begin : g_no_hundreds
         assign hundreds_in = '0;
      end
   endgenerate

   // ----------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the payload while stalled, load on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         segment_ff  <= segment_in;
         enable_ff   <= enable_in;
         units_ff    <= digits_in[0];
         tens_ff     <= tens_in;
         hundreds_ff <= hundreds_in;
         run_mode_ff <= mode_code(mode_in);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_segment_pattern = segment_ff;
   assign rsp_digit_enable    = enable_ff;
   assign rsp_units_digit     = units_ff;
   assign rsp_tens_digit      = tens_ff;
   assign rsp_hundreds_digit  = hundreds_ff;
   assign rsp_run_mode        = run_mode_ff;

endmodule
`default_nettype wire

// ===== rtl/core/tdsd_checker.sv =====
// Port-level checker for the stopwatch display, bound to the top level.
`default_nettype none
`include "three_digit_stopwatch_display_macros.svh"
module tdsd_checker
   import tdsd_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [6:0] rsp_segment_pattern,
   input wire logic [2:0] rsp_digit_enable,
   input wire logic [3:0] rsp_units_digit,
   input wire logic [3:0] rsp_tens_digit,
   input wire logic [3:0] rsp_hundreds_digit,
   input wire logic [1:0] rsp_run_mode
);

   // a stalled item holds
   `TDSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_segment_pattern) && $stable(rsp_run_mode) && $stable(rsp_units_digit))

   // at most one digit lit
   `TDSD_ASSERT_NOW(a_enable_onehot, clock, reset, rsp_valid, $onehot0(rsp_digit_enable))

   // digits stay BCD
   `TDSD_ASSERT_NOW(a_digits_bcd, clock, reset, rsp_valid, (rsp_units_digit <= BCD_MAX) && (rsp_tens_digit <= BCD_MAX) && (rsp_hundreds_digit <= BCD_MAX))

   // alarm is sticky until block reset
   `TDSD_ASSERT_NEXT(a_alarm_sticky, clock, reset, rsp_valid && (rsp_run_mode == RUN_ALARM), !rsp_valid || (rsp_run_mode == RUN_ALARM))

   // alarm shows the saturated units digit
   `TDSD_ASSERT_NOW(a_alarm_saturated, clock, reset, rsp_valid && (rsp_run_mode == RUN_ALARM), rsp_units_digit == BCD_MAX)

endmodule

bind three_digit_stopwatch_display tdsd_checker u_tdsd_checker (.*);
`default_nettype wire

// ===== sim/tb_three_digit_stopwatch_display.sv =====
// Testbench for the three-digit stopwatch display: button items in, one checked readout out.
`timescale 1ns / 100ps
module tb_three_digit_stopwatch_display;
   import tdsd_pkg::*;

   // Give up after this many clocks.
   localparam int CYCLE_LIMIT = 500000;
   localparam int MAX_REPORTS = 10;

   // Segment patterns a..g on bits 0..6 for BCD digits 0..9.
   localparam logic [6:0] GLYPH [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   // Directed button script, one entry per item: {ms_tick, start_level, clear_level}.
   // Walk start press, clear ignored while running, stop through the final period,
   // buttons ignored while stopping, clear while stopped, and both presses at once.
   localparam logic [2:0] BUTTON_SCRIPT [24] = '{
      3'b100, 3'b110, 3'b110, 3'b100, 3'b101, 3'b101, 3'b100, 3'b100,
      3'b110, 3'b010, 3'b110, 3'b111, 3'b101, 3'b100, 3'b100, 3'b101,
      3'b101, 3'b100, 3'b111, 3'b111, 3'b000, 3'b100, 3'b100, 3'b000
   };

   // One display readout, as the result channel carries it.
   typedef struct packed {
      logic [6:0] seg;
      logic [2:0] enable;
      logic [3:0] units;
      logic [3:0] tens;
      logic [3:0] hundreds;
      logic [1:0] run;
   } readout_type;

   // Mirror of the stopwatch: tracks debounce, count, mode and display scan, and
   // keeps the readouts that accepted button items still owe.
   class stopwatch_mirror_type;
      logic [7:0]  debounce_ms;
      logic [15:0] period_ms;
      logic [7:0]  mux_ms;
      logic [3:0]  digits [3];
      logic [1:0]  mode;
      logic [15:0] period_cnt;
      logic [7:0]  mux_cnt;
      logic [1:0]  mux_idx;
      logic [7:0]  settle_cnt [2];
      bit          last_raw [2];
      bit          steady [2];
      readout_type readouts_due [$];
      int          bad_readouts;
      int          readouts_seen;

      function new();
         debounce_ms = DEBOUNCE_MS_RST;
         period_ms   = COUNT_PERIOD_MS_RST;
         mux_ms      = MUX_MS_RST;
         foreach (digits[i]) digits[i] = 4'd0;
         mode       = RUN_STOPPED;
         period_cnt = 16'd0;
         mux_cnt    = 8'd0;
         mux_idx    = 2'd0;
         for (int b = 0; b < 2; b++) begin
            settle_cnt[b] = 8'd0;
            last_raw[b]   = 1'b0;
            steady[b]     = 1'b0;
         end
         bad_readouts  = 0;
         readouts_seen = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_DEBOUNCE:     debounce_ms = value[7:0];
            REG_COUNT_PERIOD: period_ms   = value[15:0];
            REG_MUX:          mux_ms      = value[7:0];
            default: ;
         endcase
      endfunction

      // Return 1 when button b turns into a debounced press this cycle.
      function bit debounce_press(int b, bit raw, bit tick);
         bit press;
         press = 1'b0;
         if (raw != last_raw[b]) begin
            settle_cnt[b] = 8'd0;
         end else begin
            if (tick && settle_cnt[b] < debounce_ms) settle_cnt[b] = settle_cnt[b] + 8'd1;
            if (settle_cnt[b] >= debounce_ms && raw != steady[b]) begin
               steady[b] = raw;
               press     = raw;
            end
         end
         last_raw[b] = raw;
         return press;
      endfunction

      // Advance the BCD count; return 1 when it was already at 999.
      function bit bump_count();
         for (int i = 0; i < 3; i++) begin
            if (digits[i] < BCD_MAX) begin
               digits[i] = digits[i] + 4'd1;
               return 1'b0;
            end
            digits[i] = 4'd0;
         end
         foreach (digits[i]) digits[i] = BCD_MAX;
         return 1'b1;
      endfunction

      // Apply one accepted button item and queue the readout it produces.
      function void take_buttons(bit tick, bit start_raw, bit clear_raw);
         bit          go;
         bit          wipe;
         bit          switched;
         int unsigned nxt;
         readout_type r;
         go       = debounce_press(0, start_raw, tick);
         wipe     = debounce_press(1, clear_raw, tick);
         switched = 1'b0;
         if (mode == RUN_STOPPED) begin
            if (go) begin
               mode       = RUN_RUNNING;
               period_cnt = 16'd0;
               switched   = 1'b1;
            end else if (wipe) begin
               foreach (digits[i]) digits[i] = 4'd0;
            end
         end else if (mode == RUN_RUNNING && go) begin
            mode       = RUN_STOPPING;
            period_cnt = 16'd0;
            switched   = 1'b1;
         end
         if (!switched && tick && (mode == RUN_RUNNING || mode == RUN_STOPPING)) begin
            nxt = period_cnt + 1;
            if (nxt >= period_ms) begin
               period_cnt = 16'd0;
               if (bump_count()) mode = RUN_ALARM;
               else if (mode == RUN_STOPPING) mode = RUN_STOPPED;
            end else begin
               period_cnt = 16'(nxt);
            end
         end
         if (tick) begin
            nxt = mux_cnt + 1;
            if (nxt >= mux_ms) begin
               mux_cnt = 8'd0;
               mux_idx = (mux_idx == 2'd2) ? 2'd0 : mux_idx + 2'd1;
            end else begin
               mux_cnt = 8'(nxt);
            end
         end
         r.seg      = GLYPH[digits[mux_idx]];
         r.enable   = 3'b001 << mux_idx;
         r.units    = digits[0];
         r.tens     = digits[1];
         r.hundreds = digits[2];
         r.run      = mode;
         readouts_due.push_back(r);
      endfunction

      // Compare one delivered readout against the oldest one owed.
      function void compare_readout(readout_type got);
         readout_type want;
         readouts_seen++;
         if (readouts_due.size() == 0) begin
            bad_readouts++;
            if (bad_readouts <= MAX_REPORTS)
               $display("readout %0d arrived with no button item pending", readouts_seen);
            return;
         end
         want = readouts_due.pop_front();
         if (got.seg !== want.seg || got.enable !== want.enable ||
             got.units !== want.units || got.tens !== want.tens ||
             got.hundreds !== want.hundreds || got.run !== want.run) begin
            bad_readouts++;
            if (bad_readouts <= MAX_REPORTS)
               $display({"readout %0d mismatch (want/got): seg %h/%h en %b/%b ",
                         "digits %0d%0d%0d/%0d%0d%0d mode %0d/%0d"}, readouts_seen,
                        want.seg, got.seg, want.enable, got.enable,
                        want.hundreds, want.tens, want.units,
                        got.hundreds, got.tens, got.units, want.run, got.run);
         end
      endfunction

      // Count every readout still owed once the run has drained.
      function void close_out();
         if (readouts_due.size() != 0) begin
            $display("%0d readouts never arrived", readouts_due.size());
            bad_readouts += readouts_due.size();
         end
      endfunction
   endclass

   // Every block input starts at a known value; reset is high from time zero.
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_ms_tick = 1'b0;
   logic              req_start_level = 1'b0;
   logic              req_clear_level = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [6:0]        rsp_segment_pattern;
   logic [2:0]        rsp_digit_enable;
   logic [3:0]        rsp_units_digit;
   logic [3:0]        rsp_tens_digit;
   logic [3:0]        rsp_hundreds_digit;
   logic [1:0]        rsp_run_mode;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   stopwatch_mirror_type mirror;

   // Idle shaping: sender gap and receiver stall odds in percent, changed per phase.
   int gap_pct = 0;
   int stall_pct = 0;
   int burst_left = 0;
   int stall_left = 0;
   bit stall_on = 1'b0;

   // Raw button levels of the random phases and how many ticks each one holds.
   bit level [2] = '{1'b0, 1'b0};
   int hold_left [2] = '{0, 0};

   int cycle_count = 0;
   int items_sent = 0;
   int readback_errors = 0;
   int settings_used = 1;

   three_digit_stopwatch_display dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_ms_tick         (req_ms_tick),
      .req_start_level     (req_start_level),
      .req_clear_level     (req_clear_level),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_segment_pattern (rsp_segment_pattern),
      .rsp_digit_enable    (rsp_digit_enable),
      .rsp_units_digit     (rsp_units_digit),
      .rsp_tens_digit      (rsp_tens_digit),
      .rsp_hundreds_digit  (rsp_hundreds_digit),
      .rsp_run_mode        (rsp_run_mode),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Stop a hung run: no handshake may stall forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result side: check each accepted readout, then pick the stall for the next edge.
   // Stall comes in runs of random length so it lands on every phase of the scan.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         mirror.compare_readout(readout_type'({rsp_segment_pattern, rsp_digit_enable,
                                               rsp_units_digit, rsp_tens_digit,
                                               rsp_hundreds_digit, rsp_run_mode}));
      if (stall_left == 0) begin
         stall_on   = ($urandom_range(0, 99) < stall_pct);
         stall_left = $urandom_range(1, 6);
      end
      stall_left--;
      rsp_stall <= stall_on;
   end

   // Send one button item; hold it until the block takes it, then feed the mirror.
   // The sender runs in bursts; a burst may open with a random gap with valid low.
   task automatic send_buttons(input bit tick, input bit start_raw, input bit clear_raw);
      int pause;
      pause = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 99) < gap_pct) pause = $urandom_range(1, 5);
      end
      burst_left--;
      if (pause != 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_ms_tick     <= tick;
      req_start_level <= start_raw;
      req_clear_level <= clear_raw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mirror.take_buttons(tick, start_raw, clear_raw);
      items_sent++;
   endtask

   // Drop valid and wait until every owed readout is in.
   task automatic settle();
      req_valid <= 1'b0;
      while (mirror.readouts_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write one register over APB, then read it back and compare.
   task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      mirror.set_reg(idx, value);
      // hold psel for the read setup
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== value) begin
         readback_errors++;
         $display("register %0d reads %h, wrote %h", idx, csr_prdata, value);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      // leave the bus idle before the next transfer
      @(posedge clock);
   endtask

   task automatic configure(input int db, input int period, input int mux);
      program_reg(REG_DEBOUNCE, db);
      program_reg(REG_COUNT_PERIOD, period);
      program_reg(REG_MUX, mux);
      settings_used++;
   endtask

   // Random button activity: mostly clean presses and releases that outlast the
   // debounce time, with about one change in five a short bounce.
   task automatic random_buttons(input int count, input int tick_pct);
      bit tick;
      for (int i = 0; i < count; i++) begin
         tick = ($urandom_range(0, 99) < tick_pct);
         for (int b = 0; b < 2; b++) begin
            if (hold_left[b] == 0) begin
               level[b] = ~level[b];
               if ($urandom_range(0, 4) == 0) hold_left[b] = $urandom_range(1, 2);
               else hold_left[b] = mirror.debounce_ms + $urandom_range(1, 8);
            end else if (tick) begin
               hold_left[b]--;
            end
         end
         send_buttons(tick, level[0], level[1]);
      end
   endtask

   initial begin
      int  n;
      int  in_alarm;
      bit  tick;
      bit  start_raw;
      bit  clear_raw;
      mirror = new();

      // Synchronous reset at the start, never again.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: long debounce, so presses are rare; light idling.
      gap_pct   = 20;
      stall_pct = 20;
      random_buttons(30, 90);
      settle();

      // Directed walk through the modes with fast timing and no idling.
      configure(1, 2, 1);
      gap_pct   = 0;
      stall_pct = 0;
      for (int i = 0; i < 24; i++)
         send_buttons(BUTTON_SCRIPT[i][2], BUTTON_SCRIPT[i][1], BUTTON_SCRIPT[i][0]);
      settle();

      // All registers zero: immediate debounce, count and scan on every tick.
      configure(0, 0, 0);
      gap_pct   = 30;
      stall_pct = 30;
      random_buttons(80, 70);
      settle();

      // Short timing, no idling on either side.
      configure(3, 5, 2);
      gap_pct   = 0;
      stall_pct = 0;
      random_buttons(80, 60);
      settle();

      // Largest values: long holds, count never advances, slow scan.
      configure(255, 65535, 255);
      gap_pct   = 20;
      stall_pct = 40;
      random_buttons(50, 100);
      settle();

      // Count every tick, heavy idling.
      configure(2, 1, 7);
      gap_pct   = 50;
      stall_pct = 60;
      random_buttons(80, 80);
      settle();

      // Run the count up to 999 and into alarm, then keep pressing buttons there.
      // Press start whenever stopped; clear bounces at random throughout.
      configure(1, 1, 3);
      gap_pct   = 25;
      stall_pct = 25;
      n        = 0;
      in_alarm = 0;
      while (in_alarm < 60) begin
         tick      = ($urandom_range(0, 99) < 95);
         start_raw = (mirror.mode == RUN_STOPPED) && (((n / 2) % 2) == 1);
         clear_raw = $urandom_range(0, 1);
         if (mirror.mode == RUN_ALARM) begin
            start_raw = $urandom_range(0, 1);
            in_alarm++;
         end
         send_buttons(tick, start_raw, clear_raw);
         n++;
      end
      settle();
      mirror.close_out();

      $display("Sent %0d button items over %0d register settings, checked %0d readouts.",
               items_sent, settings_used, mirror.readouts_seen);
      $display("Final mode %0d, %0d readout errors, %0d register readback errors.",
               mirror.mode, mirror.bad_readouts, readback_errors);
      if (mirror.bad_readouts == 0 && readback_errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tdsd_pkg.sv
rtl/core/tdsd_debounce.sv
rtl/core/tdsd_count.sv
rtl/core/tdsd_scan.sv
rtl/core/three_digit_stopwatch_display.sv
rtl/core/tdsd_checker.sv
sim/tb_three_digit_stopwatch_display.sv
